[hw/rtl/group_reverse_stream_top_macros.svh]
// Assertion macros used by the checker file of this block.
`ifndef GROUP_REVERSE_STREAM_TOP_MACROS_SVH
`define GROUP_REVERSE_STREAM_TOP_MACROS_SVH

// Property checked at every clock edge, reset included.
`define GRS_ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

// Property checked only while the active-low reset is released.
`define GRS_ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

[hw/rtl/grs_pkg.sv]
package grs_pkg;

    // Width of one item's value on both stream sides.
    localparam int DATA_W = 32;

    // Group size register.
    localparam int              GS_W     = 5;
    localparam logic [GS_W-1:0] GS_RESET = 5'd2;

    // Configuration port.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Register word index, taken from paddr[PADDR_W-1:2].
    localparam logic [PADDR_W-3:0] REG_GROUP_SIZE = 1'b0;

endpackage

[hw/rtl/group_reverse_stream_top.sv]
// Reverses a stream of signed 32-bit items in groups of k, where k is the
// group_size register (0 and 1 both act as 1, values above MAX_GROUP act as
// MAX_GROUP). Items are written into a single-port group buffer as they arrive.
// An item that completes a group starts a drain that reads the group back out in
// reverse order. An item flagged with tlast that leaves the group short of k
// starts a drain in arrival order instead. On the output, tlast marks the final
// item of each drained run, and tuser marks the item that ends the whole
// sequence. The closing item of a group of n starts n reads, issued one after
// another from the single buffer port and held off while the output stalls.
// Input tready drops only while reads are still being issued. Results already
// read wait in a read-data stage and an output register, so the next item is
// taken while they drain. The group size must be changed only while the block
// is idle. A change takes effect with the next item: if the buffer already
// holds k or more items, that item empties all of them in reverse.
module group_reverse_stream_top #(
    parameter int MAX_GROUP = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Input stream
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    input  logic signed [grs_pkg::DATA_W-1:0]     i_s_axis_tdata,  // [31:0] value
    input  logic                                  i_s_axis_tlast,  // final_element
    // Output stream
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    output logic signed [grs_pkg::DATA_W-1:0]     o_m_axis_tdata,  // [31:0] out_value
    output logic                                  o_m_axis_tlast,  // run_last
    output logic [0:0]                            o_m_axis_tuser,  // [0] sequence_end
    // Configuration port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [grs_pkg::PADDR_W-1:0]           paddr,
    input  logic [grs_pkg::PDATA_W-1:0]           pwdata,
    output logic [grs_pkg::PDATA_W-1:0]           prdata,
    output logic                                  pready
);
    import grs_pkg::*;

    // Buffer index width, count width (holds MAX_GROUP itself) and a width that
    // holds both the count and the group size register.
    localparam int AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
    localparam int CW = $clog2(MAX_GROUP + 1);
    localparam int KW = (CW > GS_W) ? CW : GS_W;

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    // Group buffer.
    logic [DATA_W-1:0] r_mem [MAX_GROUP];
    logic [DATA_W-1:0] r_mem_q;

    // Control state.
    logic            r_state;
    logic            n_state;
    logic [GS_W-1:0] r_group_size;
    logic [AW-1:0]   r_fill;
    logic [AW-1:0]   n_fill;

    // Drain sequencer.
    logic [AW-1:0]   r_rd_addr;
    logic            r_rd_rev;
    logic [CW-1:0]   r_rd_left;
    logic            r_rd_fin;

    // Read-data stage and output register.
    logic              r_s1_vld;
    logic              r_s1_last;
    logic              r_s1_end;
    logic              r_out_vld;
    logic [DATA_W-1:0] r_out_data;
    logic              r_out_last;
    logic              r_out_end;

    logic            w_in_acc;
    logic [KW-1:0]   w_gs;
    logic [KW-1:0]   w_k;
    logic [CW-1:0]   w_n;
    logic            w_full;
    logic            w_emit;
    logic            w_out_free;
    logic            w_s1_free;
    logic            w_s1_move;
    logic            w_issue;
    logic            w_rd_final;
    logic            w_cfg_wr;
    logic            w_cfg_sel;

    // Effective group size: at least one, at most MAX_GROUP.
    always_comb begin
        w_gs = KW'(r_group_size);
        if (w_gs == '0) begin
            w_k = KW'(1);
        end else if (w_gs > KW'(MAX_GROUP)) begin
            w_k = KW'(MAX_GROUP);
        end else begin
            w_k = w_gs;
        end
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;

    // Fill level once the incoming item has been stored.
    assign w_n    = CW'(r_fill) + CW'(1);
    assign w_full = (KW'(w_n) >= w_k);
    assign w_emit = w_full || i_s_axis_tlast;

    // The output register frees when it is empty or being taken; the read stage
    // frees when it is empty or moving on. A read is issued only into a free slot.
    assign w_out_free = !r_out_vld || i_m_axis_tready;
    assign w_s1_move  = r_s1_vld && w_out_free;
    assign w_s1_free  = !r_s1_vld || w_out_free;
    assign w_issue    = (r_state == ST_DRAIN) && w_s1_free;
    assign w_rd_final = (r_rd_left == CW'(1));

    always_comb begin
        n_state = r_state;
        n_fill  = r_fill;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (w_emit) begin
                        n_state = ST_DRAIN;
                        n_fill  = '0;
                    end else begin
                        n_fill = r_fill + AW'(1);
                    end
                end
            end
            ST_DRAIN: begin
                if (w_issue && w_rd_final) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Configuration port.
    assign w_cfg_sel = (paddr[PADDR_W-1:2] == REG_GROUP_SIZE);
    assign w_cfg_wr  = psel && penable && pwrite && pready && w_cfg_sel;
    assign pready    = 1'b1;
    assign prdata    = w_cfg_sel ? PDATA_W'(r_group_size) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_fill       <= '0;
            r_group_size <= GS_RESET;
            r_s1_vld     <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            if (w_cfg_wr) begin
                r_group_size <= pwdata[GS_W-1:0];
            end
            if (w_issue) begin
                r_s1_vld <= 1'b1;
            end else if (w_s1_move) begin
                r_s1_vld <= 1'b0;
            end
            if (w_s1_move) begin
                r_out_vld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Buffer port: writes happen only while idle and reads only while draining,
    // so the two never meet in one cycle.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_mem[r_fill] <= $unsigned(i_s_axis_tdata);
        end
        if (w_issue) begin
            r_mem_q <= r_mem[r_rd_addr];
        end
    end

    // Drain sequencer and payload pipeline.
    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_emit) begin
            // A full group starts from the item just written and walks down;
            // a short final group starts from the oldest item and walks up.
            r_rd_rev  <= w_full;
            r_rd_addr <= w_full ? r_fill : '0;
            r_rd_left <= w_n;
            r_rd_fin  <= i_s_axis_tlast;
        end else if (w_issue) begin
            r_rd_addr <= r_rd_rev ? (r_rd_addr - AW'(1)) : (r_rd_addr + AW'(1));
            r_rd_left <= r_rd_left - CW'(1);
        end
        if (w_issue) begin
            r_s1_last <= w_rd_final;
            r_s1_end  <= w_rd_final && r_rd_fin;
        end
        if (w_s1_move) begin
            r_out_data <= r_mem_q;
            r_out_last <= r_s1_last;
            r_out_end  <= r_s1_end;
        end
    end

    assign o_m_axis_tvalid   = r_out_vld;
    assign o_m_axis_tdata    = $signed(r_out_data);
    assign o_m_axis_tlast    = r_out_last;
    assign o_m_axis_tuser[0] = r_out_end;

endmodule

[hw/rtl/grs_checker.sv]
`include "group_reverse_stream_top_macros.svh"

module grs_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_m_axis_tvalid,
    input logic                              i_m_axis_tready,
    input logic signed [grs_pkg::DATA_W-1:0] o_m_axis_tdata,
    input logic                              o_m_axis_tlast,
    input logic [0:0]                        o_m_axis_tuser,
    input logic                              pready
);
    import grs_pkg::*;

    // Reset empties the output register.
    `GRS_ASSERT_CLK(a_rst_out_empty, i_clk,
        !i_rst_n |=> !o_m_axis_tvalid,
        "output valid after reset")

    // The item that ends the sequence always closes its run.
    `GRS_ASSERT_RST(a_end_is_last, i_clk, i_rst_n,
        (o_m_axis_tvalid && o_m_axis_tuser[0]) |-> o_m_axis_tlast,
        "sequence end without run end")

    // A stalled result holds its value and flags.
    `GRS_ASSERT_RST(a_out_hold, i_clk, i_rst_n,
        (o_m_axis_tvalid && !i_m_axis_tready) |=> (o_m_axis_tvalid &&
            $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast) && $stable(o_m_axis_tuser)),
        "stalled output changed")

    // The configuration port never inserts wait states.
    `GRS_ASSERT_RST(a_pready_high, i_clk, i_rst_n, pready, "pready low")

endmodule

bind group_reverse_stream_top grs_checker u_grs_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .pready          (pready)
);

[tb/group_reverse_checker.sv]
`timescale 1ns / 100ps

// Watches both streams and the register port, keeps its own copy of the group
// buffer and group size, and checks every output item against the predicted order.
module group_reverse_checker #(
    parameter int MAX_GROUP = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    input  logic                              i_s_tready,
    input  logic signed [grs_pkg::DATA_W-1:0] i_s_tdata,  // [31:0] value
    input  logic                              i_s_tlast,  // final_element
    input  logic                              i_m_tvalid,
    input  logic                              i_m_tready,
    input  logic signed [grs_pkg::DATA_W-1:0] i_m_tdata,  // [31:0] out_value
    input  logic                              i_m_tlast,  // run_last
    input  logic [0:0]                        i_m_tuser,  // [0] sequence_end
    input  logic                              i_psel,
    input  logic                              i_penable,
    input  logic                              i_pwrite,
    input  logic [grs_pkg::PADDR_W-1:0]       i_paddr,
    input  logic [grs_pkg::PDATA_W-1:0]       i_pwdata,
    input  logic                              i_pready,
    output int                                o_fail_count,
    output int                                o_pending,
    output int                                o_items_in,
    output int                                o_results_out
);
    import grs_pkg::*;

    localparam int FILL_W = $clog2(MAX_GROUP + 1);

    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic                     run_last;
        logic                     seq_end;
    } t_reordered_item;

    t_reordered_item          reordered_q[$];
    logic signed [DATA_W-1:0] group_store[MAX_GROUP];
    logic [FILL_W-1:0]        fill_count;
    logic [GS_W-1:0]          group_size;

    initial begin
        o_fail_count  = 0;
        o_pending     = 0;
        o_items_in    = 0;
        o_results_out = 0;
        fill_count    = '0;
        group_size    = GS_RESET;
    end

    // Stores one item and queues whatever it releases: a full group comes out
    // newest first, a short group closed by the final element in arrival order.
    task automatic predict_reorder(input logic signed [DATA_W-1:0] v, input logic fin);
        int              k;
        int              n;
        int              i;
        t_reordered_item r;
        k = (group_size < 1) ? 1 : ((group_size > MAX_GROUP) ? MAX_GROUP : int'(group_size));
        if (fill_count < MAX_GROUP) begin
            group_store[fill_count] = v;
            fill_count = fill_count + 1'b1;
        end
        n = fill_count;
        if (n >= k || fin) begin
            for (i = 0; i < n; i++) begin
                r.value    = (n >= k) ? group_store[n - 1 - i] : group_store[i];
                r.run_last = (i == n - 1);
                r.seq_end  = (i == n - 1) && fin;
                reordered_q.push_back(r);
            end
            fill_count = '0;
        end
    endtask

    task automatic compare_result();
        t_reordered_item r;
        if (reordered_q.size() == 0) begin
            $error("Unexpected output item: out_value %0d", i_m_tdata);
            o_fail_count++;
        end else begin
            r = reordered_q.pop_front();
            if (i_m_tdata !== r.value) begin
                $error("out_value: expected %0d, got %0d", r.value, i_m_tdata);
                o_fail_count++;
            end
            if (i_m_tlast !== r.run_last) begin
                $error("run_last: expected %0d, got %0d", r.run_last, i_m_tlast);
                o_fail_count++;
            end
            if (i_m_tuser[0] !== r.seq_end) begin
                $error("sequence_end: expected %0d, got %0d", r.seq_end, i_m_tuser[0]);
                o_fail_count++;
            end
        end
    endtask

    // Outputs are handled before inputs: an item taken at this edge cannot have
    // produced anything yet.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            fill_count = '0;
            group_size = GS_RESET;
            reordered_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                o_results_out++;
                compare_result();
            end
            if (i_psel && i_penable && i_pwrite && i_pready &&
                i_paddr[PADDR_W-1:2] == REG_GROUP_SIZE) begin
                group_size = i_pwdata[GS_W-1:0];
            end
            if (i_s_tvalid && i_s_tready) begin
                o_items_in++;
                predict_reorder(i_s_tdata, i_s_tlast);
            end
        end
        o_pending = reordered_q.size();
    end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps

// Top of the group-reversal testbench. It makes the stimulus on the input stream
// and the register port, drives the output-side back-pressure, and gives the
// verdict. All prediction and comparison lives in the checker instance.
module tb_top;
    import grs_pkg::*;

    localparam int MAX_GROUP   = 16;
    // Cycles allowed after the last expected item before the group size is changed
    // or the run ends: a whole group of reads plus the output pipeline.
    localparam int DRAIN_PAD   = MAX_GROUP + 8;
    // Length of the long output hold-off used to fill the block up.
    localparam int HOLD_CYCLES = 80;
    // A register word that does not exist; writes to it must be ignored.
    localparam logic [PADDR_W-3:0] REG_SPARE = 1'b1;

    logic                     i_clk           = 1'b0;
    logic                     i_rst_n         = 1'b0;
    logic                     i_s_axis_tvalid = 1'b0;
    logic                     o_s_axis_tready;
    logic signed [DATA_W-1:0] i_s_axis_tdata  = '0;  // [31:0] value
    logic                     i_s_axis_tlast  = 1'b0; // final_element
    logic                     o_m_axis_tvalid;
    logic                     i_m_axis_tready = 1'b0;
    logic signed [DATA_W-1:0] o_m_axis_tdata;         // [31:0] out_value
    logic                     o_m_axis_tlast;         // run_last
    logic [0:0]               o_m_axis_tuser;         // [0] sequence_end
    logic                     psel            = 1'b0;
    logic                     penable         = 1'b0;
    logic                     pwrite          = 1'b0;
    logic [PADDR_W-1:0]       paddr           = '0;
    logic [PDATA_W-1:0]       pwdata          = '0;
    logic [PDATA_W-1:0]       prdata;
    logic                     pready;

    int fail_count;
    int pending;
    int items_in;
    int results_out;

    // Random idling on the sender and the receiver; both are switched off for the
    // last part of the run and the sender's gaps also during the hold-off phase.
    bit gaps_on   = 1'b1;
    bit stalls_on = 1'b1;
    // Bumped by the stimulus to ask the receiver for one long hold-off.
    int hold_requests = 0;
    int size_writes   = 0;

    always #5 i_clk = ~i_clk;

    group_reverse_stream_top #(
        .MAX_GROUP(MAX_GROUP)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tlast (i_s_axis_tlast),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tlast (o_m_axis_tlast),
        .o_m_axis_tuser (o_m_axis_tuser),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    group_reverse_checker #(
        .MAX_GROUP(MAX_GROUP)
    ) checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_axis_tvalid),
        .i_s_tready   (o_s_axis_tready),
        .i_s_tdata    (i_s_axis_tdata),
        .i_s_tlast    (i_s_axis_tlast),
        .i_m_tvalid   (o_m_axis_tvalid),
        .i_m_tready   (i_m_axis_tready),
        .i_m_tdata    (o_m_axis_tdata),
        .i_m_tlast    (o_m_axis_tlast),
        .i_m_tuser    (o_m_axis_tuser),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_items_in   (items_in),
        .o_results_out(results_out)
    );

    // Receiver. Every falling edge it decides tready for the next rising edge. A
    // hold-off request is counted out here in cycles, so the sender is free to keep
    // offering items while the block fills up behind the stalled output.
    initial begin : receiver
        int stall_left;
        int holds_done;
        stall_left = 0;
        holds_done = 0;
        forever begin
            @(negedge i_clk);
            if (holds_done != hold_requests) begin
                holds_done++;
                stall_left = HOLD_CYCLES;
            end else if (stall_left == 0 && stalls_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 5);
            end
            if (stall_left > 0) begin
                i_m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    // Mostly random words, with the extremes of the signed range mixed in often.
    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Offers one item from a falling edge and returns at a falling edge once it has
    // been taken. tvalid stays high when the next item follows straight away;
    // otherwise a random gap of a few cycles is inserted.
    task automatic send_item(input logic signed [DATA_W-1:0] v, input logic fin);
        i_s_axis_tdata  <= v;
        i_s_axis_tlast  <= fin;
        i_s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        @(negedge i_clk);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
    endtask

    // Stops offering items and waits until every predicted item has come out, then
    // lets the block settle so that nothing is still in flight.
    task automatic settle_block();
        i_s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_PAD) @(negedge i_clk);
    endtask

    // One register write: setup cycle, access cycle, then the bus returns to idle.
    task automatic write_reg(input logic [PADDR_W-3:0] word, input logic [PDATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {word, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        if (word == REG_GROUP_SIZE) size_writes++;
    endtask

    // One phase at a given group size: mostly sequences closed by a final element,
    // some cut short without one so that the next phase starts on a partial group.
    task automatic run_phase(input logic [GS_W-1:0] gs, input int n_items);
        int k;
        int left;
        int run_len;
        int j;
        settle_block();
        write_reg(REG_GROUP_SIZE, PDATA_W'(gs));
        k    = (gs == 0) ? 1 : ((gs > MAX_GROUP) ? MAX_GROUP : int'(gs));
        left = n_items;
        while (left > 0) begin
            run_len = $urandom_range(1, 2 * k + 2);
            if (run_len > left) run_len = left;
            for (j = 0; j < run_len; j++) begin
                send_item(pick_value(), (j == run_len - 1) && ($urandom_range(0, 4) != 0));
            end
            left -= run_len;
        end
    endtask

    initial begin : stimulus
        logic [GS_W-1:0] phase_size[7];
        int              phase_len[7];
        int              p;
        int              i;
        phase_size = '{5'd16, 5'd0, 5'd5, 5'd31, 5'd1, 5'd7, 5'd3};
        phase_len  = '{12, 8, 12, 12, 8, 12, 15};

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part. The reset group size of two is used first: a pair with the
        // signed extremes comes out swapped, a lone final element comes out as it
        // is, and a pair closed by the final element comes out swapped with the
        // sequence end on its last item.
        send_item(32'sh7FFF_FFFF, 1'b0);
        send_item(32'sh8000_0000, 1'b0);
        send_item(-32'sd1, 1'b1);
        send_item('0, 1'b0);
        send_item(-32'sd1, 1'b1);

        // Two items are left in a group of three, then the size is lowered to one:
        // the next item empties all three, newest first.
        settle_block();
        write_reg(REG_GROUP_SIZE, 32'd3);
        send_item(32'sd1, 1'b0);
        send_item(32'sd2, 1'b0);
        settle_block();
        write_reg(REG_GROUP_SIZE, 32'd1);
        send_item(32'sd3, 1'b0);

        // A write to a register that does not exist must leave the size at one.
        settle_block();
        write_reg(REG_SPARE, 32'd5);
        send_item(pick_value(), 1'b0);

        // A size above the buffer depth saturates: sixteen items form one group,
        // closed here by the final element.
        settle_block();
        write_reg(REG_GROUP_SIZE, 32'd31);
        for (i = 0; i < MAX_GROUP; i++) begin
            send_item(pick_value(), i == MAX_GROUP - 1);
        end

        // Pressure: the receiver holds off for a long stretch while items keep
        // coming back to back, so the block must stall its input. The sender then
        // waits for every result before carrying on.
        settle_block();
        write_reg(REG_GROUP_SIZE, 32'd4);
        gaps_on = 1'b0;
        hold_requests++;
        for (i = 0; i < 24; i++) begin
            send_item(pick_value(), i == 23);
        end
        gaps_on = 1'b1;
        settle_block();

        // Random part over several group sizes, the extremes among them. The last
        // phase runs with no idling on either side.
        for (p = 0; p < 7; p++) begin
            if (p == 6) begin
                gaps_on   = 1'b0;
                stalls_on = 1'b0;
            end
            run_phase(phase_size[p], phase_len[p]);
        end

        settle_block();
        $display("Run covered %0d input items and %0d output items over %0d group sizes,",
                 items_in, results_out, size_writes + 1);
        $display("including zero, one, sixteen and saturating sizes and a long output stall.");
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Guard against a hung handshake or results that never arrive.
    initial begin : watchdog
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

[group_reverse_stream_top.f]
+incdir+hw/rtl
hw/rtl/grs_pkg.sv
hw/rtl/group_reverse_stream_top.sv
hw/rtl/grs_checker.sv
tb/group_reverse_checker.sv
tb/tb_top.sv
